FILE: design/rwrfd_pkg.sv
// ----------------------------------------------------------------------------
// rwrfd_pkg
// Types and fixed constants shared by the height window rate and flying
// detect block.
// ----------------------------------------------------------------------------
package rwrfd_pkg;

    localparam int HEIGHT_W   = 12;
    localparam int SUM_W      = 17;
    localparam int RATE_W     = 16;
    localparam int DEBOUNCE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // rate = diff * RATE_NUM * Q_ONE / (WINDOW * RATE_DEN)
    localparam int RATE_NUM   = 61;
    localparam int RATE_DEN   = 100;
    localparam int Q_ONE      = 256;
    localparam int RECIP_SHIFT = 24;

    localparam logic [HEIGHT_W-1:0]   TAKEOFF_RESET  = 12'd30;
    localparam logic [HEIGHT_W-1:0]   LANDING_RESET  = 12'd18;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd30;
    localparam logic [DEBOUNCE_W-1:0] COUNT_MAX      = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAKEOFF  = 2'd0,
        CFG_LANDING  = 2'd1,
        CFG_DEBOUNCE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0]   takeoff_threshold_cm;
        logic [HEIGHT_W-1:0]   landing_threshold_cm;
        logic [DEBOUNCE_W-1:0] debounce_period;
    } detect_cfg_t;

endpackage

FILE: design/range_window_rate_and_flying_detect_top.sv
// ----------------------------------------------------------------------------
// range_window_rate_and_flying_detect_top
// Windowed height rate estimator with a debounced flying detector.
//
// Input channel: height_cm with sample_valid / sample_stall; an item is
// taken at a clock edge with sample_valid high and sample_stall low.
// Output channel: height_out_cm, window_sum, vertical_rate, is_flying with
// result_valid / result_stall, one result item per input item, in order.
// Configuration: cfg_write, cfg_index, cfg_data; index 0 take-off threshold,
// 1 landing threshold, 2 debounce period, other indexes are ignored.
// Each item passes from the read stage into the output register, which
// presents its result; a stall at the output can hold the read stage.
// Throughput: one item per cycle while result_stall is low; the ring is
// read one stage ahead of its write-back, so consecutive items touch
// different slots. Reset empties the ring through per-slot valid flags,
// clears sum, index, flag and count, and loads the configuration defaults;
// sample_stall is low out of reset, so items are taken from then on.
// A stalled result holds in the output register; one more item may sit in
// the read stage, and sample_stall rises only while both are occupied.
// ----------------------------------------------------------------------------
module range_window_rate_and_flying_detect_top
    import rwrfd_pkg::*;
#(
    parameter int WINDOW = 30
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  logic [HEIGHT_W-1:0]       height_cm,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [HEIGHT_W-1:0]       height_out_cm,
    output logic [SUM_W-1:0]          window_sum,
    output logic signed [RATE_W-1:0]  vertical_rate,
    output logic                      is_flying
);

    localparam int IDX_W = $clog2(WINDOW);

    detect_cfg_t cfg_reg;

    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                s1_valid_reg;
    logic [HEIGHT_W-1:0] s1_h_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;

    logic                out_valid_reg;
    logic [HEIGHT_W-1:0] out_h_reg;
    logic [SUM_W-1:0]    out_sum_reg;
    logic [RATE_W-1:0]   out_rate_reg;
    logic                out_flying_reg;

    logic                accept;
    logic                s1_go;
    logic [HEIGHT_W-1:0] dropped;
    logic signed [RATE_W-1:0] rate;
    logic                flying_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.takeoff_threshold_cm <= TAKEOFF_RESET;
            cfg_reg.landing_threshold_cm <= LANDING_RESET;
            cfg_reg.debounce_period      <= DEBOUNCE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TAKEOFF:  cfg_reg.takeoff_threshold_cm <= cfg_data;
                CFG_LANDING:  cfg_reg.landing_threshold_cm <= cfg_data;
                CFG_DEBOUNCE: cfg_reg.debounce_period <= cfg_data[DEBOUNCE_W-1:0];
                default:      ;
            endcase
        end
    end

    // read stage moves on when the output register is free or draining
    assign s1_go        = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !s1_go;
    assign accept       = sample_valid && !sample_stall;

    assign idx_next = (idx_reg == IDX_W'(WINDOW - 1)) ? '0 : idx_reg + 1'b1;
    assign sum_next = sum_reg + SUM_W'(s1_h_reg) - SUM_W'(dropped);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                idx_reg <= idx_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_h_reg   <= height_cm;
            s1_idx_reg <= idx_next;
        end
    end

    rwrfd_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (idx_next),
        .rd_data (dropped),
        .wr_en   (s1_go),
        .wr_addr (s1_idx_reg),
        .wr_data (s1_h_reg)
    );

    rwrfd_rate #(
        .WINDOW (WINDOW)
    ) u_rate (
        .new_cm     (s1_h_reg),
        .dropped_cm (dropped),
        .rate       (rate)
    );

    rwrfd_detect u_detect (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .update      (s1_go),
        .height_cm   (s1_h_reg),
        .flying_next (flying_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_h_reg      <= s1_h_reg;
            out_sum_reg    <= sum_next;
            out_rate_reg   <= rate;
            out_flying_reg <= flying_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign height_out_cm = out_h_reg;
    assign window_sum    = out_sum_reg;
    assign vertical_rate = out_rate_reg;
    assign is_flying     = out_flying_reg;

endmodule

FILE: design/rwrfd_ring.sv
// ----------------------------------------------------------------------------
// rwrfd_ring
// Sample ring memory: one write port, one registered read port, and one
// valid flag per slot so that reset empties the ring at once.
// ----------------------------------------------------------------------------
module rwrfd_ring
    import rwrfd_pkg::*;
#(
    parameter int WINDOW = 30
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(WINDOW)-1:0]   rd_addr,
    output logic [HEIGHT_W-1:0]         rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(WINDOW)-1:0]   wr_addr,
    input  logic [HEIGHT_W-1:0]         wr_data
);

    logic [HEIGHT_W-1:0] mem [WINDOW];
    logic [WINDOW-1:0]   slot_valid_reg;
    logic [HEIGHT_W-1:0] rd_data_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                slot_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= slot_valid_reg[rd_addr];
            end
        end
    end

    // a slot never written since reset reads as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: design/rwrfd_rate.sv
// ----------------------------------------------------------------------------
// rwrfd_rate
// Scales the sample difference to a Q8.8 rate: constant reciprocal multiply,
// truncation toward zero and saturation to 16 bits.
// ----------------------------------------------------------------------------
module rwrfd_rate
    import rwrfd_pkg::*;
#(
    parameter int WINDOW = 30
)
(
    input  logic [HEIGHT_W-1:0]      new_cm,
    input  logic [HEIGHT_W-1:0]      dropped_cm,
    output logic signed [RATE_W-1:0] rate
);

    localparam longint RATE_DIV   = WINDOW * RATE_DEN;
    localparam longint RATE_SCALE = RATE_NUM * Q_ONE;
    // rounded up; with a 24 bit shift the quotient is exact for 12 bit inputs
    localparam longint RATE_RECIP =
        ((RATE_SCALE << RECIP_SHIFT) + RATE_DIV - 1) / RATE_DIV;
    localparam int RECIP_W = $clog2(RATE_RECIP + 1);
    localparam int PROD_W  = RECIP_W + HEIGHT_W;
    localparam int QUOT_W  = PROD_W - RECIP_SHIFT;
    // wide enough to hold the saturation limits
    localparam int CMP_W   = ((QUOT_W > RATE_W) ? QUOT_W : RATE_W) + 1;

    logic [HEIGHT_W:0]   diff;
    logic                neg;
    logic [HEIGHT_W-1:0] mag;
    logic [PROD_W-1:0]   prod;
    logic [QUOT_W-1:0]   quot;
    logic [CMP_W-1:0]    quot_ext;

    always_comb
    begin
        diff     = {1'b0, new_cm} - {1'b0, dropped_cm};
        neg      = diff[HEIGHT_W];
        mag      = neg ? HEIGHT_W'(-diff) : diff[HEIGHT_W-1:0];
        prod     = PROD_W'(mag) * PROD_W'(RATE_RECIP[RECIP_W-1:0]);
        quot     = prod[PROD_W-1:RECIP_SHIFT];
        quot_ext = CMP_W'(quot);
        if (neg)
        begin
            if (quot_ext >= CMP_W'(32768))
            begin
                rate = 16'sh8000;
            end
            else
            begin
                rate = RATE_W'(-quot_ext);
            end
        end
        else
        begin
            if (quot_ext > CMP_W'(32767))
            begin
                rate = 16'sh7fff;
            end
            else
            begin
                rate = RATE_W'(quot_ext);
            end
        end
    end

endmodule

FILE: design/rwrfd_detect.sv
// ----------------------------------------------------------------------------
// rwrfd_detect
// Hysteresis flying detector with a debounce count of consecutive
// qualifying samples.
// ----------------------------------------------------------------------------
module rwrfd_detect
    import rwrfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  detect_cfg_t         cfg,
    input  logic                update,
    input  logic [HEIGHT_W-1:0] height_cm,
    output logic                flying_next
);

    logic                  flying_reg;
    logic [DEBOUNCE_W-1:0] count_reg;
    logic [DEBOUNCE_W-1:0] count_next;
    logic [DEBOUNCE_W-1:0] count_inc;
    logic                  qualifies;

    always_comb
    begin
        if (flying_reg)
        begin
            qualifies = height_cm < cfg.landing_threshold_cm;
        end
        else
        begin
            qualifies = height_cm > cfg.takeoff_threshold_cm;
        end
        count_inc   = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
        flying_next = flying_reg;
        count_next  = '0;
        if (qualifies)
        begin
            if (count_inc > cfg.debounce_period)
            begin
                flying_next = !flying_reg;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flying_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (update)
        begin
            flying_reg <= flying_next;
            count_reg  <= count_next;
        end
    end

endmodule
